// File: src/bps_pkg.sv
// ============================================================================
// bps_pkg
// Shared codes and field widths for the bend program sequencer.
// ============================================================================
package bps_pkg;

    localparam int FIELD_W = 24;

    localparam logic [3:0] MODE_ADD    = 4'd0;
    localparam logic [3:0] MODE_REMOVE = 4'd1;
    localparam logic [3:0] MODE_READ   = 4'd2;
    localparam logic [3:0] MODE_CLEAR  = 4'd3;
    localparam logic [3:0] MODE_START  = 4'd4;
    localparam logic [3:0] MODE_STOP   = 4'd5;
    localparam logic [3:0] MODE_PAUSE  = 4'd6;
    localparam logic [3:0] MODE_RESUME = 4'd7;
    localparam logic [3:0] MODE_TICK   = 4'd8;

    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_PUSH     = 3'd1;
    localparam logic [2:0] PH_BEND     = 3'd2;
    localparam logic [2:0] PH_RETURN   = 3'd3;
    localparam logic [2:0] PH_ROTATE   = 3'd4;
    localparam logic [2:0] PH_COMPLETE = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_BAD_IDX  = 2'd2;
    localparam logic [1:0] ST_NO_STEPS = 2'd3;

    localparam logic [1:0] AX_PUSH     = 2'd0;
    localparam logic [1:0] AX_BEND     = 2'd1;
    localparam logic [1:0] AX_ROTATE   = 2'd2;

    localparam logic [1:0] RS_STOPPED  = 2'd0;
    localparam logic [1:0] RS_RUNNING  = 2'd1;
    localparam logic [1:0] RS_PAUSED   = 2'd2;

endpackage

// File: src/bps_table.sv
// ============================================================================
// bps_table
// Step table memory: one write port, one read port, registered read data.
// ============================================================================
module bps_table #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 72
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/bend_program_sequencer.sv
// ============================================================================
// bend_program_sequencer
// Step table editor and push / bend / return / rotate run sequencer.
// ============================================================================
// One item is handled at a time. Add, clear, start, stop, pause, resume,
// failed reads and ticks that need no table entry go from the execute state
// straight to the result state; reads of a stored entry and ticks that look
// up the current step first pass a wait state for the registered read data
// of the step table. Remove shifts each later entry down before its result,
// a read state and a write state per entry, through the table's one read
// port and one write port. A new item is accepted while the previous result
// still waits in the output register.
module bend_program_sequencer #(
    parameter int MAX_STEPS   = 64,
    parameter int VALUE_WIDTH = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [3:0]  mode,
    input  logic [5:0]  index,
    input  logic signed [23:0] push_distance,
    input  logic signed [23:0] bend_angle,
    input  logic signed [23:0] rotation,
    input  logic        push_busy,
    input  logic        bend_busy,
    input  logic        rotate_busy,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        cmd_valid,
    output logic [1:0]  cmd_axis,
    output logic signed [23:0] cmd_value,
    output logic        run_strobe,
    output logic [1:0]  run_state,
    output logic [2:0]  phase,
    output logic [6:0]  step_index,
    output logic [6:0]  step_count,
    output logic [1:0]  status,
    output logic signed [23:0] read_push,
    output logic signed [23:0] read_angle,
    output logic signed [23:0] read_rotation
);

    localparam int AW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam int CW = $clog2(MAX_STEPS + 1);
    localparam int VW = VALUE_WIDTH;
    localparam int DW = 3 * VALUE_WIDTH;
    localparam int FW = bps_pkg::FIELD_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_WAIT,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_RESULT
    } state_t;

    // control state
    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] step_reg, step_next;
    logic [2:0]    phase_reg, phase_next;
    logic          running_reg, running_next;
    logic          paused_reg, paused_next;
    logic          issued_reg, issued_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic          out_valid_reg, out_valid_next;

    // captured item
    logic [3:0]    mode_reg, mode_next;
    logic [5:0]    index_reg, index_next;
    logic [VW-1:0] push_in_reg, push_in_next;
    logic [VW-1:0] angle_in_reg, angle_in_next;
    logic [VW-1:0] rot_in_reg, rot_in_next;
    logic [2:0]    busy_reg, busy_next;

    // pending result
    logic          res_cmd_valid_reg, res_cmd_valid_next;
    logic [1:0]    res_cmd_axis_reg, res_cmd_axis_next;
    logic [FW-1:0] res_cmd_value_reg, res_cmd_value_next;
    logic          res_strobe_reg, res_strobe_next;
    logic [1:0]    res_status_reg, res_status_next;
    logic [FW-1:0] res_read_push_reg, res_read_push_next;
    logic [FW-1:0] res_read_angle_reg, res_read_angle_next;
    logic [FW-1:0] res_read_rot_reg, res_read_rot_next;

    // output register
    logic          cmd_valid_reg, cmd_valid_next;
    logic [1:0]    cmd_axis_reg, cmd_axis_next;
    logic [FW-1:0] cmd_value_reg, cmd_value_next;
    logic          run_strobe_reg, run_strobe_next;
    logic [1:0]    run_state_reg, run_state_next;
    logic [2:0]    phase_out_reg, phase_out_next;
    logic [6:0]    step_index_reg, step_index_next;
    logic [6:0]    step_count_reg, step_count_next;
    logic [1:0]    status_reg, status_next;
    logic [FW-1:0] read_push_reg, read_push_next;
    logic [FW-1:0] read_angle_reg, read_angle_next;
    logic [FW-1:0] read_rot_reg, read_rot_next;

    // table port
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [DW-1:0] mem_wd;
    logic [AW-1:0] mem_ra;
    logic [DW-1:0] mem_rd;
    logic [VW-1:0] rd_push;
    logic [VW-1:0] rd_angle;
    logic [VW-1:0] rd_rot;
    logic          idx_ok;

    bps_table #(
        .DEPTH (MAX_STEPS),
        .AW    (AW),
        .DW    (DW)
    ) u_table (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_wa),
        .wr_data (mem_wd),
        .rd_addr (mem_ra),
        .rd_data (mem_rd)
    );

    assign rd_push  = mem_rd[DW-1:2*VW];
    assign rd_angle = mem_rd[2*VW-1:VW];
    assign rd_rot   = mem_rd[VW-1:0];
    assign idx_ok   = 32'(index_reg) < 32'(count_reg);

    always_comb
    begin
        logic [1:0]    axis;
        logic [VW-1:0] target;

        axis   = bps_pkg::AX_PUSH;
        target = '0;

        state_next     = state_reg;
        count_next     = count_reg;
        step_next      = step_reg;
        phase_next     = phase_reg;
        running_next   = running_reg;
        paused_next    = paused_reg;
        issued_next    = issued_reg;
        ptr_next       = ptr_reg;
        out_valid_next = out_valid_reg;

        mode_next     = mode_reg;
        index_next    = index_reg;
        push_in_next  = push_in_reg;
        angle_in_next = angle_in_reg;
        rot_in_next   = rot_in_reg;
        busy_next     = busy_reg;

        res_cmd_valid_next  = res_cmd_valid_reg;
        res_cmd_axis_next   = res_cmd_axis_reg;
        res_cmd_value_next  = res_cmd_value_reg;
        res_strobe_next     = res_strobe_reg;
        res_status_next     = res_status_reg;
        res_read_push_next  = res_read_push_reg;
        res_read_angle_next = res_read_angle_reg;
        res_read_rot_next   = res_read_rot_reg;

        cmd_valid_next  = cmd_valid_reg;
        cmd_axis_next   = cmd_axis_reg;
        cmd_value_next  = cmd_value_reg;
        run_strobe_next = run_strobe_reg;
        run_state_next  = run_state_reg;
        phase_out_next  = phase_out_reg;
        step_index_next = step_index_reg;
        step_count_next = step_count_reg;
        status_next     = status_reg;
        read_push_next  = read_push_reg;
        read_angle_next = read_angle_reg;
        read_rot_next   = read_rot_reg;

        mem_we = 1'b0;
        mem_wa = count_reg[AW-1:0];
        mem_wd = {push_in_reg, angle_in_reg, rot_in_reg};
        mem_ra = step_reg[AW-1:0];

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next     = mode;
                    index_next    = index;
                    push_in_next  = VW'(push_distance);
                    angle_in_next = VW'(bend_angle);
                    rot_in_next   = VW'(rotation);
                    busy_next     = {rotate_busy, bend_busy, push_busy};
                    state_next    = S_EXEC;
                end
            end

            S_EXEC:
            begin
                res_cmd_valid_next  = 1'b0;
                res_cmd_axis_next   = bps_pkg::AX_PUSH;
                res_cmd_value_next  = '0;
                res_strobe_next     = 1'b0;
                res_status_next     = bps_pkg::ST_OK;
                res_read_push_next  = '0;
                res_read_angle_next = '0;
                res_read_rot_next   = '0;
                state_next          = S_RESULT;

                unique case (mode_reg)
                    bps_pkg::MODE_ADD:
                    begin
                        if (count_reg == CW'(MAX_STEPS))
                        begin
                            res_status_next = bps_pkg::ST_FULL;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                    end

                    bps_pkg::MODE_REMOVE:
                    begin
                        if (!idx_ok)
                        begin
                            res_status_next = bps_pkg::ST_BAD_IDX;
                        end
                        else if (32'(index_reg) + 32'd1 < 32'(count_reg))
                        begin
                            ptr_next   = CW'(index_reg);
                            state_next = S_SHIFT_RD;
                        end
                        else
                        begin
                            count_next = count_reg - CW'(1);
                        end
                    end

                    bps_pkg::MODE_READ:
                    begin
                        if (!idx_ok)
                        begin
                            res_status_next = bps_pkg::ST_BAD_IDX;
                        end
                        else
                        begin
                            mem_ra     = AW'(index_reg);
                            state_next = S_WAIT;
                        end
                    end

                    bps_pkg::MODE_CLEAR, bps_pkg::MODE_STOP:
                    begin
                        if (mode_reg == bps_pkg::MODE_CLEAR)
                        begin
                            count_next = '0;
                        end
                        running_next = 1'b0;
                        paused_next  = 1'b0;
                        step_next    = '0;
                        phase_next   = bps_pkg::PH_IDLE;
                        issued_next  = 1'b0;
                    end

                    bps_pkg::MODE_START:
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = bps_pkg::ST_NO_STEPS;
                        end
                        else
                        begin
                            running_next = 1'b1;
                            paused_next  = 1'b0;
                            step_next    = '0;
                            phase_next   = bps_pkg::PH_PUSH;
                            issued_next  = 1'b0;
                        end
                    end

                    bps_pkg::MODE_PAUSE:
                    begin
                        paused_next = 1'b1;
                    end

                    bps_pkg::MODE_RESUME:
                    begin
                        paused_next = 1'b0;
                    end

                    bps_pkg::MODE_TICK:
                    begin
                        if (running_reg && !paused_reg)
                        begin
                            if (step_reg >= count_reg)
                            begin
                                running_next = 1'b0;
                            end
                            else if (phase_reg == bps_pkg::PH_COMPLETE)
                            begin
                                step_next   = step_reg + CW'(1);
                                issued_next = 1'b0;
                                if (32'(step_reg) + 32'd1 >= 32'(count_reg))
                                begin
                                    running_next = 1'b0;
                                end
                                else
                                begin
                                    phase_next = bps_pkg::PH_PUSH;
                                end
                            end
                            else if (phase_reg != bps_pkg::PH_IDLE &&
                                     phase_reg <= bps_pkg::PH_ROTATE)
                            begin
                                mem_ra     = step_reg[AW-1:0];
                                state_next = S_WAIT;
                            end
                        end
                    end

                    default:
                    begin
                    end
                endcase
            end

            S_WAIT:
            begin
                state_next = S_RESULT;
                if (mode_reg == bps_pkg::MODE_READ)
                begin
                    res_read_push_next  = FW'(rd_push);
                    res_read_angle_next = FW'(rd_angle);
                    res_read_rot_next   = FW'(rd_rot);
                end
                else
                begin
                    unique case (phase_reg)
                        bps_pkg::PH_PUSH:
                        begin
                            axis   = bps_pkg::AX_PUSH;
                            target = rd_push;
                        end
                        bps_pkg::PH_BEND:
                        begin
                            axis   = bps_pkg::AX_BEND;
                            target = rd_angle;
                        end
                        bps_pkg::PH_RETURN:
                        begin
                            axis   = bps_pkg::AX_BEND;
                            target = '0;
                        end
                        default:
                        begin
                            axis   = bps_pkg::AX_ROTATE;
                            target = rd_rot;
                        end
                    endcase

                    if (phase_reg == bps_pkg::PH_ROTATE && target == '0)
                    begin
                        phase_next  = bps_pkg::PH_COMPLETE;
                        issued_next = 1'b0;
                    end
                    else if (busy_reg[axis])
                    begin
                        res_strobe_next = 1'b1;
                    end
                    else if (!issued_reg)
                    begin
                        res_cmd_valid_next = 1'b1;
                        res_cmd_axis_next  = axis;
                        res_cmd_value_next = FW'(target);
                        issued_next        = 1'b1;
                    end
                    else
                    begin
                        phase_next  = phase_reg + 3'd1;
                        issued_next = 1'b0;
                    end
                end
            end

            S_SHIFT_RD:
            begin
                mem_ra     = AW'(ptr_reg + CW'(1));
                state_next = S_SHIFT_WR;
            end

            S_SHIFT_WR:
            begin
                mem_we   = 1'b1;
                mem_wa   = ptr_reg[AW-1:0];
                mem_wd   = mem_rd;
                ptr_next = ptr_reg + CW'(1);
                if (32'(ptr_reg) + 32'd2 < 32'(count_reg))
                begin
                    state_next = S_SHIFT_RD;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_RESULT;
                end
            end

            S_RESULT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd_valid_next  = res_cmd_valid_reg;
                    cmd_axis_next   = res_cmd_axis_reg;
                    cmd_value_next  = res_cmd_value_reg;
                    run_strobe_next = res_strobe_reg;
                    if (!running_reg)
                    begin
                        run_state_next = bps_pkg::RS_STOPPED;
                    end
                    else if (paused_reg)
                    begin
                        run_state_next = bps_pkg::RS_PAUSED;
                    end
                    else
                    begin
                        run_state_next = bps_pkg::RS_RUNNING;
                    end
                    phase_out_next  = phase_reg;
                    step_index_next = 7'(step_reg);
                    step_count_next = 7'(count_reg);
                    status_next     = res_status_reg;
                    read_push_next  = res_read_push_reg;
                    read_angle_next = res_read_angle_reg;
                    read_rot_next   = res_read_rot_reg;
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            phase_reg     <= bps_pkg::PH_IDLE;
            running_reg   <= 1'b0;
            paused_reg    <= 1'b0;
            issued_reg    <= 1'b0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;

            mode_reg     <= '0;
            index_reg    <= '0;
            push_in_reg  <= '0;
            angle_in_reg <= '0;
            rot_in_reg   <= '0;
            busy_reg     <= '0;

            res_cmd_valid_reg  <= 1'b0;
            res_cmd_axis_reg   <= bps_pkg::AX_PUSH;
            res_cmd_value_reg  <= '0;
            res_strobe_reg     <= 1'b0;
            res_status_reg     <= bps_pkg::ST_OK;
            res_read_push_reg  <= '0;
            res_read_angle_reg <= '0;
            res_read_rot_reg   <= '0;

            cmd_valid_reg  <= 1'b0;
            cmd_axis_reg   <= bps_pkg::AX_PUSH;
            cmd_value_reg  <= '0;
            run_strobe_reg <= 1'b0;
            run_state_reg  <= bps_pkg::RS_STOPPED;
            phase_out_reg  <= bps_pkg::PH_IDLE;
            step_index_reg <= '0;
            step_count_reg <= '0;
            status_reg     <= bps_pkg::ST_OK;
            read_push_reg  <= '0;
            read_angle_reg <= '0;
            read_rot_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            step_reg      <= step_next;
            phase_reg     <= phase_next;
            running_reg   <= running_next;
            paused_reg    <= paused_next;
            issued_reg    <= issued_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;

            mode_reg     <= mode_next;
            index_reg    <= index_next;
            push_in_reg  <= push_in_next;
            angle_in_reg <= angle_in_next;
            rot_in_reg   <= rot_in_next;
            busy_reg     <= busy_next;

            res_cmd_valid_reg  <= res_cmd_valid_next;
            res_cmd_axis_reg   <= res_cmd_axis_next;
            res_cmd_value_reg  <= res_cmd_value_next;
            res_strobe_reg     <= res_strobe_next;
            res_status_reg     <= res_status_next;
            res_read_push_reg  <= res_read_push_next;
            res_read_angle_reg <= res_read_angle_next;
            res_read_rot_reg   <= res_read_rot_next;

            cmd_valid_reg  <= cmd_valid_next;
            cmd_axis_reg   <= cmd_axis_next;
            cmd_value_reg  <= cmd_value_next;
            run_strobe_reg <= run_strobe_next;
            run_state_reg  <= run_state_next;
            phase_out_reg  <= phase_out_next;
            step_index_reg <= step_index_next;
            step_count_reg <= step_count_next;
            status_reg     <= status_next;
            read_push_reg  <= read_push_next;
            read_angle_reg <= read_angle_next;
            read_rot_reg   <= read_rot_next;
        end
    end

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = out_valid_reg;
    assign cmd_valid     = cmd_valid_reg;
    assign cmd_axis      = cmd_axis_reg;
    assign cmd_value     = cmd_value_reg;
    assign run_strobe    = run_strobe_reg;
    assign run_state     = run_state_reg;
    assign phase         = phase_out_reg;
    assign step_index    = step_index_reg;
    assign step_count    = step_count_reg;
    assign status        = status_reg;
    assign read_push     = read_push_reg;
    assign read_angle    = read_angle_reg;
    assign read_rotation = read_rot_reg;

endmodule

// File: test/tb_bend_program_sequencer.sv
// ============================================================================
// tb_bend_program_sequencer
// Self-checking bench for the bend program sequencer. A directed table covers
// the no-steps and bad-index error codes, value extremes, the stopped, paused
// and missing-step cases and one partial run; random programs follow: table
// edits, full runs with random axis busy flags, table fills and raw noise.
// Pinned rows are checked against fixed results, the rest against an in-bench
// predictor, with random idling on both sides and one long output hold-off.
// ============================================================================
module tb_bend_program_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          TABLE_DEPTH    = 64;
    localparam int          ITEM_TARGET    = 530;
    localparam int          LONG_HOLD      = 300;
    localparam int          DRAIN_CYCLES   = 20;
    localparam logic [3:0]  MODE_UNUSED_LO = 4'd9;
    localparam logic [3:0]  MODE_UNUSED_HI = 4'd15;
    localparam logic [2:0]  BUSY_NONE      = 3'b000;
    localparam logic [2:0]  BUSY_PUSH      = 3'b001;
    localparam logic [2:0]  BUSY_ALL       = 3'b111;
    localparam logic signed [23:0] VAL_MAX  = 24'sh7FFFFF;
    localparam logic signed [23:0] VAL_MIN  = 24'sh800000;
    localparam logic signed [23:0] VAL_NEG1 = 24'shFFFFFF;

    typedef struct packed {
        logic [3:0]         mode;
        logic [5:0]         index;
        logic signed [23:0] push;
        logic signed [23:0] angle;
        logic signed [23:0] rot;
        logic               push_busy;
        logic               bend_busy;
        logic               rotate_busy;
    } item_t;

    typedef struct packed {
        logic               cmd_valid;
        logic [1:0]         cmd_axis;
        logic signed [23:0] cmd_value;
        logic               run_strobe;
        logic [1:0]         run_state;
        logic [2:0]         phase;
        logic [6:0]         step_index;
        logic [6:0]         step_count;
        logic [1:0]         status;
        logic signed [23:0] read_push;
        logic signed [23:0] read_angle;
        logic signed [23:0] read_rotation;
    } result_t;

    typedef struct packed {
        item_t   it;
        logic    pinned;
        result_t res;
    } plan_row_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [3:0]         mode;
    logic [5:0]         index;
    logic signed [23:0] push_distance;
    logic signed [23:0] bend_angle;
    logic signed [23:0] rotation;
    logic               push_busy;
    logic               bend_busy;
    logic               rotate_busy;
    logic               out_valid;
    logic               out_stall;
    logic               cmd_valid;
    logic [1:0]         cmd_axis;
    logic signed [23:0] cmd_value;
    logic               run_strobe;
    logic [1:0]         run_state;
    logic [2:0]         phase;
    logic [6:0]         step_index;
    logic [6:0]         step_count;
    logic [1:0]         status;
    logic signed [23:0] read_push;
    logic signed [23:0] read_angle;
    logic signed [23:0] read_rotation;

    bend_program_sequencer i_dut (.*);

    always #1ns clk = ~clk;

    // predictor state
    logic signed [23:0] push_tbl  [0:TABLE_DEPTH-1];
    logic signed [23:0] angle_tbl [0:TABLE_DEPTH-1];
    logic signed [23:0] rot_tbl   [0:TABLE_DEPTH-1];
    int unsigned        n_steps   = 0;
    int unsigned        cur_step  = 0;
    logic [2:0]         run_ph    = bps_pkg::PH_IDLE;
    bit                 running   = 1'b0;
    bit                 paused    = 1'b0;
    bit                 issued    = 1'b0;

    plan_row_t item_plan [$];
    result_t   expected_q [$];
    int        n_directed    = 0;
    int        n_sent        = 0;
    int        n_checked     = 0;
    int        n_errors      = 0;
    int        n_moves       = 0;
    int        n_strobes     = 0;
    int        n_full        = 0;
    int        n_bad_index   = 0;
    int        runs_finished = 0;

    function automatic item_t op(input logic [3:0] m, input logic [5:0] ix = '0,
                                 input logic signed [23:0] p = '0,
                                 input logic signed [23:0] a = '0,
                                 input logic signed [23:0] r = '0,
                                 input logic [2:0] busy = BUSY_NONE);
        item_t it;
        it.mode        = m;
        it.index       = ix;
        it.push        = p;
        it.angle       = a;
        it.rot         = r;
        it.push_busy   = busy[0];
        it.bend_busy   = busy[1];
        it.rotate_busy = busy[2];
        return it;
    endfunction

    function automatic result_t settled(input logic [1:0] st, input logic [1:0] rs,
                                        input logic [2:0] ph, input logic [6:0] cnt,
                                        input logic signed [23:0] rp = '0,
                                        input logic signed [23:0] ra = '0,
                                        input logic signed [23:0] rr = '0);
        result_t r;
        r               = '0;
        r.status        = st;
        r.run_state     = rs;
        r.phase         = ph;
        r.step_count    = cnt;
        r.read_push     = rp;
        r.read_angle    = ra;
        r.read_rotation = rr;
        return r;
    endfunction

    function automatic logic signed [23:0] rand_value();
        case ($urandom_range(0, 9))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2:       return '0;
            3:       return VAL_NEG1;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [2:0] rand_busy();
        logic [2:0] b;
        for (int i = 0; i < 3; i++)
            b[i] = ($urandom_range(0, 99) < 35);
        return b;
    endfunction

    task automatic plan(input item_t it, input logic pinned = 1'b0,
                        input result_t res = '0);
        plan_row_t row;
        row.it     = it;
        row.pinned = pinned;
        row.res    = res;
        item_plan.insert(item_plan.size(), row);
    endtask

    task automatic plan_add();
        logic signed [23:0] r;
        r = ($urandom_range(0, 9) < 3) ? '0 : rand_value();
        plan(op(bps_pkg::MODE_ADD, 6'($urandom), rand_value(), rand_value(), r));
    endtask

    task automatic plan_run();
        int k;
        int n_ticks;
        k = $urandom_range(1, 4);
        if ($urandom_range(0, 9) < 8)
            plan(op(bps_pkg::MODE_CLEAR));
        repeat (k) plan_add();
        if ($urandom_range(0, 1))
            plan(op(bps_pkg::MODE_READ, 6'($urandom_range(0, 7))));
        plan(op(bps_pkg::MODE_START));
        n_ticks = 14 * k + $urandom_range(0, 10);
        repeat (n_ticks)
        begin
            case ($urandom_range(0, 99))
                0, 1, 2:
                begin
                    plan(op(bps_pkg::MODE_PAUSE));
                    plan(op(bps_pkg::MODE_TICK, '0, '0, '0, '0, rand_busy()));
                    plan(op(bps_pkg::MODE_RESUME));
                end
                3, 4:    plan(op(bps_pkg::MODE_REMOVE, 6'($urandom_range(0, 5))));
                5:       plan(op(bps_pkg::MODE_STOP));
                6, 7:    plan(op(bps_pkg::MODE_READ, 6'($urandom)));
                8:       plan_add();
                default: plan(op(bps_pkg::MODE_TICK, 6'($urandom), '0, '0, '0, rand_busy()));
            endcase
        end
    endtask

    task automatic plan_fill();
        plan(op(bps_pkg::MODE_CLEAR));
        repeat (TABLE_DEPTH + 2) plan_add();
        repeat (4) plan(op(bps_pkg::MODE_READ, 6'($urandom)));
        plan(op(bps_pkg::MODE_REMOVE, 6'd63));
        plan(op(bps_pkg::MODE_REMOVE, 6'd0));
        plan(op(bps_pkg::MODE_REMOVE, 6'($urandom)));
        plan(op(bps_pkg::MODE_START));
        repeat (20) plan(op(bps_pkg::MODE_TICK, '0, '0, '0, '0, rand_busy()));
        plan(op(bps_pkg::MODE_STOP));
    endtask

    task automatic plan_noise();
        repeat ($urandom_range(5, 10))
            plan(op(4'($urandom), 6'($urandom), 24'($urandom), 24'($urandom),
                    24'($urandom), 3'($urandom)));
    endtask

    task automatic halt_run();
        running  = 1'b0;
        paused   = 1'b0;
        cur_step = 0;
        run_ph   = bps_pkg::PH_IDLE;
        issued   = 1'b0;
    endtask

    task automatic predict_sequencer(input item_t it, output result_t r);
        logic [2:0]         busy;
        logic [1:0]         ax;
        logic signed [23:0] tgt;
        r    = '0;
        busy = {it.rotate_busy, it.bend_busy, it.push_busy};
        case (it.mode)
            bps_pkg::MODE_ADD:
                if (n_steps >= TABLE_DEPTH)
                begin
                    r.status = bps_pkg::ST_FULL;
                end
                else
                begin
                    push_tbl[n_steps]  = it.push;
                    angle_tbl[n_steps] = it.angle;
                    rot_tbl[n_steps]   = it.rot;
                    n_steps++;
                end
            bps_pkg::MODE_REMOVE:
                if (it.index >= n_steps)
                begin
                    r.status = bps_pkg::ST_BAD_IDX;
                end
                else
                begin
                    for (int i = int'(it.index); i + 1 < n_steps; i++)
                    begin
                        push_tbl[i]  = push_tbl[i+1];
                        angle_tbl[i] = angle_tbl[i+1];
                        rot_tbl[i]   = rot_tbl[i+1];
                    end
                    n_steps--;
                end
            bps_pkg::MODE_READ:
                if (it.index >= n_steps)
                begin
                    r.status = bps_pkg::ST_BAD_IDX;
                end
                else
                begin
                    r.read_push     = push_tbl[it.index];
                    r.read_angle    = angle_tbl[it.index];
                    r.read_rotation = rot_tbl[it.index];
                end
            bps_pkg::MODE_CLEAR:
            begin
                n_steps = 0;
                halt_run();
            end
            bps_pkg::MODE_START:
                if (n_steps == 0)
                begin
                    r.status = bps_pkg::ST_NO_STEPS;
                end
                else
                begin
                    running  = 1'b1;
                    paused   = 1'b0;
                    cur_step = 0;
                    run_ph   = bps_pkg::PH_PUSH;
                    issued   = 1'b0;
                end
            bps_pkg::MODE_STOP:   halt_run();
            bps_pkg::MODE_PAUSE:  paused = 1'b1;
            bps_pkg::MODE_RESUME: paused = 1'b0;
            bps_pkg::MODE_TICK:
                if (running && !paused)
                begin
                    if (cur_step >= n_steps)
                    begin
                        // step removed under the run
                        running = 1'b0;
                    end
                    else if (run_ph == bps_pkg::PH_COMPLETE)
                    begin
                        cur_step++;
                        if (cur_step >= n_steps)
                        begin
                            running = 1'b0;
                            runs_finished++;
                        end
                        else
                        begin
                            run_ph = bps_pkg::PH_PUSH;
                        end
                        issued = 1'b0;
                    end
                    else if (run_ph >= bps_pkg::PH_PUSH && run_ph <= bps_pkg::PH_ROTATE)
                    begin
                        case (run_ph)
                            bps_pkg::PH_PUSH:
                            begin
                                ax  = bps_pkg::AX_PUSH;
                                tgt = push_tbl[cur_step];
                            end
                            bps_pkg::PH_BEND:
                            begin
                                ax  = bps_pkg::AX_BEND;
                                tgt = angle_tbl[cur_step];
                            end
                            bps_pkg::PH_RETURN:
                            begin
                                ax  = bps_pkg::AX_BEND;
                                tgt = '0;
                            end
                            default:
                            begin
                                ax  = bps_pkg::AX_ROTATE;
                                tgt = rot_tbl[cur_step];
                            end
                        endcase
                        if (run_ph == bps_pkg::PH_ROTATE && tgt == 0)
                        begin
                            run_ph = bps_pkg::PH_COMPLETE;
                            issued = 1'b0;
                        end
                        else if (busy[ax])
                        begin
                            r.run_strobe = 1'b1;
                        end
                        else if (!issued)
                        begin
                            r.cmd_valid = 1'b1;
                            r.cmd_axis  = ax;
                            r.cmd_value = tgt;
                            issued      = 1'b1;
                        end
                        else
                        begin
                            run_ph = run_ph + 3'd1;
                            issued = 1'b0;
                        end
                    end
                end
            default: ;
        endcase
        r.run_state  = running ? (paused ? bps_pkg::RS_PAUSED : bps_pkg::RS_RUNNING)
                               : bps_pkg::RS_STOPPED;
        r.phase      = run_ph;
        r.step_index = cur_step[6:0];
        r.step_count = n_steps[6:0];
    endtask

    function automatic void cmp(input string name, input logic [23:0] want,
                                input logic [23:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            n_errors++;
        end
    endfunction

    // stimulus and prediction
    initial
    begin
        plan_row_t row;
        result_t   res;
        int        gap;
        bit        send_tight;
        send_tight    = 1'b0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        mode          = '0;
        index         = '0;
        push_distance = '0;
        bend_angle    = '0;
        rotation      = '0;
        push_busy     = 1'b0;
        bend_busy     = 1'b0;
        rotate_busy   = 1'b0;

        plan(op(bps_pkg::MODE_START), 1'b1,
             settled(bps_pkg::ST_NO_STEPS, bps_pkg::RS_STOPPED, bps_pkg::PH_IDLE, 7'd0));
        plan(op(bps_pkg::MODE_REMOVE), 1'b1,
             settled(bps_pkg::ST_BAD_IDX, bps_pkg::RS_STOPPED, bps_pkg::PH_IDLE, 7'd0));
        plan(op(bps_pkg::MODE_READ, 6'h3F), 1'b1,
             settled(bps_pkg::ST_BAD_IDX, bps_pkg::RS_STOPPED, bps_pkg::PH_IDLE, 7'd0));
        plan(op(bps_pkg::MODE_PAUSE), 1'b1,
             settled(bps_pkg::ST_OK, bps_pkg::RS_STOPPED, bps_pkg::PH_IDLE, 7'd0));
        plan(op(bps_pkg::MODE_TICK, '0, '0, '0, '0, BUSY_ALL), 1'b1,
             settled(bps_pkg::ST_OK, bps_pkg::RS_STOPPED, bps_pkg::PH_IDLE, 7'd0));
        plan(op(bps_pkg::MODE_RESUME), 1'b1,
             settled(bps_pkg::ST_OK, bps_pkg::RS_STOPPED, bps_pkg::PH_IDLE, 7'd0));
        plan(op(MODE_UNUSED_LO, 6'h3F, VAL_MAX, VAL_MAX, VAL_MAX, BUSY_ALL), 1'b1,
             settled(bps_pkg::ST_OK, bps_pkg::RS_STOPPED, bps_pkg::PH_IDLE, 7'd0));
        plan(op(MODE_UNUSED_HI, 6'h2A, VAL_MIN, VAL_MIN, VAL_MIN), 1'b1,
             settled(bps_pkg::ST_OK, bps_pkg::RS_STOPPED, bps_pkg::PH_IDLE, 7'd0));
        plan(op(bps_pkg::MODE_ADD, '0, VAL_MAX, VAL_MIN, '0), 1'b1,
             settled(bps_pkg::ST_OK, bps_pkg::RS_STOPPED, bps_pkg::PH_IDLE, 7'd1));
        plan(op(bps_pkg::MODE_START), 1'b1,
             settled(bps_pkg::ST_OK, bps_pkg::RS_RUNNING, bps_pkg::PH_PUSH, 7'd1));
        plan(op(bps_pkg::MODE_REMOVE), 1'b1,
             settled(bps_pkg::ST_OK, bps_pkg::RS_RUNNING, bps_pkg::PH_PUSH, 7'd0));
        plan(op(bps_pkg::MODE_TICK), 1'b1,
             settled(bps_pkg::ST_OK, bps_pkg::RS_STOPPED, bps_pkg::PH_PUSH, 7'd0));
        plan(op(bps_pkg::MODE_CLEAR), 1'b1,
             settled(bps_pkg::ST_OK, bps_pkg::RS_STOPPED, bps_pkg::PH_IDLE, 7'd0));
        plan(op(bps_pkg::MODE_ADD, '0, VAL_MIN, VAL_MAX, VAL_NEG1), 1'b1,
             settled(bps_pkg::ST_OK, bps_pkg::RS_STOPPED, bps_pkg::PH_IDLE, 7'd1));
        plan(op(bps_pkg::MODE_ADD, '0, VAL_MAX, VAL_MIN, '0), 1'b1,
             settled(bps_pkg::ST_OK, bps_pkg::RS_STOPPED, bps_pkg::PH_IDLE, 7'd2));
        plan(op(bps_pkg::MODE_READ, 6'd0), 1'b1,
             settled(bps_pkg::ST_OK, bps_pkg::RS_STOPPED, bps_pkg::PH_IDLE, 7'd2,
                     VAL_MIN, VAL_MAX, VAL_NEG1));
        plan(op(bps_pkg::MODE_READ, 6'd2), 1'b1,
             settled(bps_pkg::ST_BAD_IDX, bps_pkg::RS_STOPPED, bps_pkg::PH_IDLE, 7'd2));
        plan(op(bps_pkg::MODE_START), 1'b1,
             settled(bps_pkg::ST_OK, bps_pkg::RS_RUNNING, bps_pkg::PH_PUSH, 7'd2));
        plan(op(bps_pkg::MODE_TICK, '0, '0, '0, '0, BUSY_PUSH));
        plan(op(bps_pkg::MODE_TICK));
        plan(op(bps_pkg::MODE_TICK));
        plan(op(bps_pkg::MODE_PAUSE));
        plan(op(bps_pkg::MODE_TICK));
        plan(op(bps_pkg::MODE_RESUME));
        plan(op(bps_pkg::MODE_STOP), 1'b1,
             settled(bps_pkg::ST_OK, bps_pkg::RS_STOPPED, bps_pkg::PH_IDLE, 7'd2));
        n_directed = item_plan.size();

        plan_fill();
        while (item_plan.size() < ITEM_TARGET)
        begin
            case ($urandom_range(0, 19))
                0:                 plan_fill();
                1, 2, 3, 4, 5, 6:  plan_noise();
                default:           plan_run();
            endcase
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        while (item_plan.size() != 0)
        begin
            row = item_plan.pop_front();
            if ($urandom_range(0, 19) == 0)
                send_tight = !send_tight;
            gap = send_tight ? 0 : int'($urandom_range(0, 8));
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid      <= 1'b1;
            mode          <= row.it.mode;
            index         <= row.it.index;
            push_distance <= row.it.push;
            bend_angle    <= row.it.angle;
            rotation      <= row.it.rot;
            push_busy     <= row.it.push_busy;
            bend_busy     <= row.it.bend_busy;
            rotate_busy   <= row.it.rotate_busy;
            do @(posedge clk); while (in_stall);
            predict_sequencer(row.it, res);
            expected_q.insert(expected_q.size(), row.pinned ? row.res : res);
            n_sent++;
        end
        in_valid <= 1'b0;

        while (expected_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d items driven (%0d directed), %0d results checked, %0d errors",
                 n_sent, n_directed, n_checked, n_errors);
        $display("%0d move commands, %0d busy strobes, %0d table full, %0d bad index,",
                 n_moves, n_strobes, n_full, n_bad_index);
        $display("%0d runs played to the last step", runs_finished);
        if (n_errors == 0)
            $display("** bend_program_sequencer: PASSED **");
        else
            $display("** bend_program_sequencer: FAILED **");
        $finish;
    end

    // output side stalls, with one long hold-off to back the block up
    initial
    begin
        int hold;
        bit recv_tight;
        bit long_hold_done;
        recv_tight     = 1'b0;
        long_hold_done = 1'b0;
        out_stall      = 1'b1;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 19) == 0)
                recv_tight = !recv_tight;
            hold = recv_tight ? 0 : int'($urandom_range(0, 8));
            if (!long_hold_done && n_checked >= 150)
            begin
                hold           = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid === 1'b1 && !out_stall));
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid === 1'b1 && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                $error("result with no item outstanding");
                n_errors++;
            end
            else
            begin
                want = expected_q.pop_front();
                n_checked++;
                if (want.cmd_valid)
                    n_moves++;
                if (want.run_strobe)
                    n_strobes++;
                if (want.status == bps_pkg::ST_FULL)
                    n_full++;
                if (want.status == bps_pkg::ST_BAD_IDX)
                    n_bad_index++;
                cmp("cmd_valid",     24'(want.cmd_valid),  24'(cmd_valid));
                cmp("cmd_axis",      24'(want.cmd_axis),   24'(cmd_axis));
                cmp("cmd_value",     want.cmd_value,       cmd_value);
                cmp("run_strobe",    24'(want.run_strobe), 24'(run_strobe));
                cmp("run_state",     24'(want.run_state),  24'(run_state));
                cmp("phase",         24'(want.phase),      24'(phase));
                cmp("step_index",    24'(want.step_index), 24'(step_index));
                cmp("step_count",    24'(want.step_count), 24'(step_count));
                cmp("status",        24'(want.status),     24'(status));
                cmp("read_push",     want.read_push,       read_push);
                cmp("read_angle",    want.read_angle,      read_angle);
                cmp("read_rotation", want.read_rotation,   read_rotation);
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("timeout: %0d results still outstanding", expected_q.size());
        $display("** bend_program_sequencer: FAILED **");
        $finish;
    end

endmodule
